// ===== rtl/repeating_sequence_detector_macros.svh =====
// ----------------------------------------------------------------------------
// Repeating sequence detector assertion macros
// Shared concurrent assertion forms for the detector's RTL.
// ----------------------------------------------------------------------------
`ifndef REPEATING_SEQUENCE_DETECTOR_MACROS_SVH
`define REPEATING_SEQUENCE_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define RSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Repeating sequence detector package
// Sizes, codes, state types and control structures shared by the detector.
// ----------------------------------------------------------------------------
package rsd_pkg;

	// History depth must be a power of two so that ring addresses wrap freely.
	localparam int HISTORY_DEPTH = 512;
	localparam int SAMPLE_WIDTH  = 16;
	localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
	localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
	localparam int MIN_HIST_W    = 10;
	localparam int CMP_W         = (CNT_W > MIN_HIST_W) ? CNT_W : MIN_HIST_W;

	localparam logic [MIN_HIST_W-1:0] MIN_HIST_RESET = MIN_HIST_W'(50);
	localparam logic [CNT_W-1:0]      FILL_MAX       = CNT_W'(HISTORY_DEPTH);

	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} top_state_t;

	typedef enum logic {
		SR_IDLE,
		SR_RUN
	} srch_state_t;

	typedef struct packed {
		logic              start;
		logic [ADDR_W-1:0] base;
		logic [CNT_W-1:0]  len;
	} srch_req_t;

	typedef struct packed {
		logic done;
		logic found;
	} srch_sts_t;

endpackage

// ===== rtl/rsd_ram.sv =====
// ----------------------------------------------------------------------------
// Repeating sequence detector history RAM
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module rsd_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

// ===== rtl/rsd_search.sv =====
// ----------------------------------------------------------------------------
// Repeating sequence detector period search
// Walks candidate periods and compares each held entry with the one a period
// earlier, one pair per cycle between mismatches, via the RAM read ports.
// ----------------------------------------------------------------------------
module rsd_search (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  rsd_pkg::srch_req_t                         req,
	input  logic [rsd_pkg::SAMPLE_WIDTH-1:0]           rd_data_a,
	input  logic [rsd_pkg::SAMPLE_WIDTH-1:0]           rd_data_b,
	output logic [rsd_pkg::ADDR_W-1:0]                 rd_addr_a,
	output logic [rsd_pkg::ADDR_W-1:0]                 rd_addr_b,
	output rsd_pkg::srch_sts_t                         sts
);

	import rsd_pkg::*;

	srch_state_t       state_q;
	srch_state_t       state_d;
	logic [ADDR_W-1:0] base_q;
	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  half_q;
	logic [CNT_W-1:0]  p_q;
	logic [CNT_W-1:0]  i_q;
	logic              valid_s1;
	logic              last_s1;

	logic              mismatch;
	logic              hit;
	logic              issue;
	logic              exhaust;
	logic [CNT_W-1:0]  p_inc;
	logic [CNT_W-1:0]  back_idx;

	assign mismatch = valid_s1 && (rd_data_a != rd_data_b);
	assign hit      = valid_s1 && last_s1 && !mismatch;
	assign issue    = (state_q == SR_RUN) && (i_q < len_q) && !mismatch;
	assign p_inc    = p_q + CNT_W'(1);
	assign exhaust  = mismatch && (p_inc > half_q);
	assign back_idx = i_q - p_q;

	assign rd_addr_a = base_q + i_q[ADDR_W-1:0];
	assign rd_addr_b = base_q + back_idx[ADDR_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SR_IDLE: begin
				if (req.start) begin
					state_d = SR_RUN;
				end
			end
			SR_RUN: begin
				if (hit || exhaust) begin
					state_d = SR_IDLE;
				end
			end
			default: state_d = SR_IDLE;
		endcase
	end

	always_comb begin
		sts = '0;
		unique case (state_q)
			SR_IDLE: sts = '0;
			SR_RUN: begin
				sts.done  = hit || exhaust;
				sts.found = hit;
			end
			default: sts = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SR_IDLE;
			valid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == SR_IDLE) begin
				valid_s1 <= 1'b0;
			end else if (hit || exhaust || mismatch) begin
				valid_s1 <= 1'b0;
			end else begin
				valid_s1 <= issue;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SR_IDLE) begin
			if (req.start) begin
				base_q <= req.base;
				len_q  <= req.len;
				half_q <= req.len >> 1;
				p_q    <= CNT_W'(1);
				i_q    <= CNT_W'(1);
			end
		end else if (mismatch) begin
			p_q <= p_inc;
			i_q <= p_inc;
		end else if (issue) begin
			i_q     <= i_q + CNT_W'(1);
			last_s1 <= (i_q == len_q - CNT_W'(1));
		end
	end

endmodule

// ===== rtl/repeating_sequence_detector.sv =====
// ----------------------------------------------------------------------------
// Repeating sequence detector
// Keeps a ring of recent samples and raises a sticky flag on a zero sample or
// when the held history is exactly periodic.
// ----------------------------------------------------------------------------
// Each transfer on the input channel gives exactly one end_found result. A
// clear, a zero sample, a push with the flag already set or with fewer than
// min_history (or fewer than two) samples held goes straight to the done
// state, and its result is placed in the output register from there once that
// register is free. Any other push runs a period search that compares one pair
// of history entries per cycle, between mismatches, through the two read ports
// of the history RAM, trying periods from 1 up to L/2 for a history of L
// samples and moving on at the first mismatch; when the search ends, the done
// state places the result in the output register once that register is free.
// The input is stalled until the result has been placed in the output
// register, which then waits for its own transfer without holding up the next
// item.
`include "repeating_sequence_detector_macros.svh"

module repeating_sequence_detector (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rsd_pkg::MIN_HIST_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic [15:0]                     sample_value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            end_found
);

	import rsd_pkg::*;

	top_state_t            state_q;
	top_state_t            state_d;
	logic [ADDR_W-1:0]     wp_q;
	logic [CNT_W-1:0]      fill_q;
	logic                  flag_q;
	logic [MIN_HIST_W-1:0] min_hist_q;
	logic                  out_valid_q;
	logic                  end_found_q;

	logic                    in_acc;
	logic                    push;
	logic                    out_free;
	logic [SAMPLE_WIDTH-1:0] sample;
	logic [ADDR_W-1:0]       wp_next;
	logic [CNT_W-1:0]        fill_next;
	logic                    run_search;
	srch_req_t               req;
	srch_sts_t               sts;
	logic [ADDR_W-1:0]       rd_addr_a;
	logic [ADDR_W-1:0]       rd_addr_b;
	logic [SAMPLE_WIDTH-1:0] rd_data_a;
	logic [SAMPLE_WIDTH-1:0] rd_data_b;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign end_found = end_found_q;

	assign in_acc    = in_valid && !in_stall;
	assign push      = in_acc && (command == CMD_PUSH);
	assign out_free  = !out_valid_q || !out_stall;
	assign sample    = SAMPLE_WIDTH'(sample_value);
	assign wp_next   = wp_q + ADDR_W'(1);
	assign fill_next = (fill_q == FILL_MAX) ? fill_q : fill_q + CNT_W'(1);

	assign run_search = push && (sample != '0) && !flag_q
		&& (CMP_W'(fill_next) >= CMP_W'(min_hist_q)) && (fill_next >= CNT_W'(2));

	assign req.start = run_search;
	assign req.len   = fill_next;
	assign req.base  = wp_next - fill_next[ADDR_W-1:0];

	rsd_ram #(
		.DEPTH (HISTORY_DEPTH),
		.WIDTH (SAMPLE_WIDTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (push),
		.wr_addr   (wp_q),
		.wr_data   (sample),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	rsd_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.sts       (sts)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = run_search ? ST_SEARCH : ST_DONE;
				end
			end
			ST_SEARCH: begin
				if (sts.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			fill_q      <= '0;
			flag_q      <= 1'b0;
			min_hist_q  <= MIN_HIST_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				min_hist_q <= cfg_data;
			end
			if (in_acc) begin
				if (command == CMD_CLEAR) begin
					wp_q   <= '0;
					fill_q <= '0;
					flag_q <= 1'b0;
				end else begin
					wp_q   <= wp_next;
					fill_q <= fill_next;
					if (sample == '0) begin
						flag_q <= 1'b1;
					end
				end
			end
			if ((state_q == ST_SEARCH) && sts.found) begin
				flag_q <= 1'b1;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			end_found_q <= flag_q;
		end
	end

	`RSD_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, in_acc, state_q != ST_IDLE, "accepted item did not start work")
	`RSD_ASSERT_NEXT(a_clear_drops_flag, clk, arst_n, in_acc && (command == CMD_CLEAR), !flag_q && (fill_q == '0), "clear did not empty history")
	`RSD_ASSERT_NEXT(a_flag_sticky, clk, arst_n, flag_q && !(in_acc && (command == CMD_CLEAR)), flag_q, "detected flag dropped without clear")
	`RSD_ASSERT_IMPL(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FILL_MAX, "fill count beyond history depth")

endmodule
